// ===== rtl/gmo_pkg.sv =====
// ============================================================================
// gmo_pkg - shared constants and angle tables for the gradient core
// Fixed-point formats, angle constants and result codes used by the
// gradient front end, the rotation cells and the quotient cells.
// ============================================================================
package gmo_pkg;

    // Default pixel width of the stream
    localparam int unsigned PIXEL_BITS_DEF = 8;

    // Rotation arithmetic: angles in Q60 radians, vector scaled by 2^40
    localparam int unsigned CORDIC_STEPS = 46;
    localparam int unsigned VEC_SHIFT    = 40;
    localparam int unsigned ANGLE_W      = 64;
    localparam int unsigned OFFSET_W     = ANGLE_W - 1;

    // Orientation quotient and result codes
    localparam int unsigned QUOT_BITS    = 9;
    localparam int unsigned ORIENT_BITS  = 8;
    localparam logic [ORIENT_BITS-1:0] ORIENT_MAX  = 8'd254;
    localparam logic [ORIENT_BITS-1:0] ORIENT_FLAT = 8'd127;
    localparam logic [ORIENT_BITS-1:0] ORIENT_PI   = 8'd0;

    localparam logic [ANGLE_W-1:0] ONE_Q60 = 64'd1 << 60;

    typedef logic signed [ANGLE_W-1:0] t_angle;

    // pi in Q60 by Machin's formula: 16*atan(1/5) - 4*atan(1/239)
    function automatic logic [ANGLE_W-1:0] calc_pi();
        logic [ANGLE_W-1:0] pw5;
        logic [ANGLE_W-1:0] pw239;
        logic [ANGLE_W-1:0] a5;
        logic [ANGLE_W-1:0] a239;
        logic [ANGLE_W-1:0] term;
        int unsigned n;
        pw5   = ONE_Q60 / 64'd5;
        pw239 = ONE_Q60 / 64'd239;
        a5    = '0;
        a239  = '0;
        for (n = 0; n < 32; n++) begin
            term  = pw5 / 64'(2 * n + 1);
            a5    = n[0] ? a5 - term : a5 + term;
            pw5   = pw5 / 64'd25;
            term  = pw239 / 64'(2 * n + 1);
            a239  = n[0] ? a239 - term : a239 + term;
            pw239 = pw239 / 64'd57121;
        end
        return (a5 << 4) - (a239 << 2);
    endfunction

    localparam t_angle PI_Q60 = t_angle'(calc_pi());

    // atan(2^-i) in Q60 by its power series; step zero is pi/4
    function automatic t_angle atan_pow2(input int unsigned i);
        logic [ANGLE_W-1:0] sum;
        logic [ANGLE_W-1:0] term;
        int unsigned n;
        int unsigned s;
        sum = '0;
        if (i == 0) begin
            sum = PI_Q60 >> 2;
        end else begin
            for (n = 0; n < 31; n++) begin
                s = i * (2 * n + 1);
                if (s <= 60) begin
                    term = (64'd1 << (60 - s)) / 64'(2 * n + 1);
                    sum  = n[0] ? sum - term : sum + term;
                end
            end
        end
        return t_angle'(sum);
    endfunction

    // Width of one orientation bin in Q60 radians
    localparam logic [ANGLE_W-1:0] ORIENT_STEP = (2 * PI_Q60) / 255;

endpackage

// ===== rtl/gmo_front.sv =====
// ============================================================================
// gmo_front - gradient front end
// Forms the halved differences, the squared length and the starting vector
// of the angle rotation, folded into the right half plane.
// ============================================================================
module gmo_front #(
    parameter int unsigned PIXEL_BITS = gmo_pkg::PIXEL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [PIXEL_BITS-1:0]             i_p00,
    input  logic [PIXEL_BITS-1:0]             i_p01,
    input  logic [PIXEL_BITS-1:0]             i_p10,
    input  logic [PIXEL_BITS-1:0]             i_p11,
    output logic                              o_valid,
    output logic signed [PIXEL_BITS:0]        o_gx,
    output logic signed [PIXEL_BITS:0]        o_gy,
    output logic [2*PIXEL_BITS:0]             o_sq,
    output logic signed [PIXEL_BITS+gmo_pkg::VEC_SHIFT+2:0] o_x,
    output logic signed [PIXEL_BITS+gmo_pkg::VEC_SHIFT+2:0] o_y,
    output gmo_pkg::t_angle                   o_z
);
    import gmo_pkg::*;

    localparam int unsigned GB  = PIXEL_BITS + 1;
    localparam int unsigned DW  = PIXEL_BITS + 3;
    localparam int unsigned SQW = 2 * GB - 1;
    localparam int unsigned XW  = GB + VEC_SHIFT + 2;

    logic signed [DW-1:0]   dx, dy, hx, hy, tx, ty;
    logic signed [GB-1:0]   gx, gy, xn, yn;
    logic signed [2*GB-1:0] px, py;
    logic                   r_valid;
    logic signed [GB-1:0]   r_gx, r_gy;
    logic [SQW-1:0]         r_sq;
    logic signed [XW-1:0]   r_x, r_y;
    t_angle                 r_z, n_z;

    always_comb begin
        dx = $signed({3'b000, i_p11}) + $signed({3'b000, i_p01})
           - $signed({3'b000, i_p10}) - $signed({3'b000, i_p00});
        dy = $signed({3'b000, i_p11}) + $signed({3'b000, i_p10})
           - $signed({3'b000, i_p01}) - $signed({3'b000, i_p00});
        // halve toward zero: bias negative values by one before the shift
        hx = dx + $signed({{(DW-1){1'b0}}, dx[DW-1]});
        hy = dy + $signed({{(DW-1){1'b0}}, dy[DW-1]});
        tx = hx >>> 1;
        ty = hy >>> 1;
        gx = tx[GB-1:0];
        gy = ty[GB-1:0];
        px = gx * gx;
        py = gy * gy;
        // fold left half plane over by a half turn
        xn = gx[GB-1] ? -gx : gx;
        yn = gx[GB-1] ? -gy : gy;
        if (gx[GB-1]) begin
            n_z = (gy > 0) ? PI_Q60 : -PI_Q60;
        end else begin
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gx <= gx;
            r_gy <= gy;
            r_sq <= px[SQW-1:0] + py[SQW-1:0];
            r_x  <= {{2{xn[GB-1]}}, xn, {VEC_SHIFT{1'b0}}};
            r_y  <= {{2{yn[GB-1]}}, yn, {VEC_SHIFT{1'b0}}};
            r_z  <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_gx    = r_gx;
    assign o_gy    = r_gy;
    assign o_sq    = r_sq;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

// ===== rtl/gmo_rot_cell.sv =====
// ============================================================================
// gmo_rot_cell - one rotation step, with one square root digit in the leading cells
// Rotates the vector toward the x axis by atan(2^-IDX) and, in the leading
// cells, settles one bit of the integer square root.
// ============================================================================
module gmo_rot_cell #(
    parameter int unsigned GRAD_BITS = gmo_pkg::PIXEL_BITS_DEF + 1,
    parameter int unsigned IDX       = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic signed [GRAD_BITS-1:0]            i_gx,
    input  logic signed [GRAD_BITS-1:0]            i_gy,
    input  logic [2*GRAD_BITS-2:0]                 i_rem,
    input  logic [GRAD_BITS-1:0]                   i_root,
    input  logic signed [GRAD_BITS+gmo_pkg::VEC_SHIFT+1:0] i_x,
    input  logic signed [GRAD_BITS+gmo_pkg::VEC_SHIFT+1:0] i_y,
    input  gmo_pkg::t_angle                        i_z,
    output logic                                   o_valid,
    output logic signed [GRAD_BITS-1:0]            o_gx,
    output logic signed [GRAD_BITS-1:0]            o_gy,
    output logic [2*GRAD_BITS-2:0]                 o_rem,
    output logic [GRAD_BITS-1:0]                   o_root,
    output logic signed [GRAD_BITS+gmo_pkg::VEC_SHIFT+1:0] o_x,
    output logic signed [GRAD_BITS+gmo_pkg::VEC_SHIFT+1:0] o_y,
    output gmo_pkg::t_angle                        o_z
);
    import gmo_pkg::*;

    localparam int unsigned SQW = 2 * GRAD_BITS - 1;
    localparam int unsigned XW  = GRAD_BITS + VEC_SHIFT + 2;
    localparam t_angle STEP_ANGLE = atan_pow2(IDX);

    logic signed [XW-1:0]     xs, ys, n_x, n_y;
    t_angle                   n_z;
    logic [SQW-1:0]           n_rem;
    logic [GRAD_BITS-1:0]     n_root;
    logic                     r_valid;
    logic signed [GRAD_BITS-1:0] r_gx, r_gy;
    logic [SQW-1:0]           r_rem;
    logic [GRAD_BITS-1:0]     r_root;
    logic signed [XW-1:0]     r_x, r_y;
    t_angle                   r_z;

    always_comb begin
        xs = i_x >>> IDX;
        ys = i_y >>> IDX;
        if (i_y > 0) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + STEP_ANGLE;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - STEP_ANGLE;
        end
    end

    generate
        if (IDX < GRAD_BITS) begin : g_digit
            localparam int unsigned B  = GRAD_BITS - 1 - IDX;
            localparam int unsigned TW = 2 * GRAD_BITS + 1;
            logic [TW-1:0] trial;
            // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
            always_comb begin
                trial = (TW'(i_root) << (B + 1)) + (TW'(1) << (2 * B));
                if (TW'(i_rem) >= trial) begin
                    n_rem  = SQW'(TW'(i_rem) - trial);
                    n_root = i_root | (GRAD_BITS'(1) << B);
                end else begin
                    n_rem  = i_rem;
                    n_root = i_root;
                end
            end
        end else begin : g_pass
            assign n_rem  = i_rem;
            assign n_root = i_root;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gx   <= i_gx;
            r_gy   <= i_gy;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_gx    = r_gx;
    assign o_gy    = r_gy;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

// ===== rtl/gmo_div_cell.sv =====
// ============================================================================
// gmo_div_cell - one restoring division digit
// Compares the angle offset against one bin width shifted by BIT and
// appends the quotient bit.
// ============================================================================
module gmo_div_cell #(
    parameter int unsigned GRAD_BITS = gmo_pkg::PIXEL_BITS_DEF + 1,
    parameter int unsigned BIT       = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [GRAD_BITS-1:0]     i_gx,
    input  logic signed [GRAD_BITS-1:0]     i_gy,
    input  logic [GRAD_BITS-1:0]            i_mag,
    input  logic [gmo_pkg::OFFSET_W-1:0]    i_rem,
    input  logic [gmo_pkg::QUOT_BITS-1:0]   i_quot,
    output logic                            o_valid,
    output logic signed [GRAD_BITS-1:0]     o_gx,
    output logic signed [GRAD_BITS-1:0]     o_gy,
    output logic [GRAD_BITS-1:0]            o_mag,
    output logic [gmo_pkg::OFFSET_W-1:0]    o_rem,
    output logic [gmo_pkg::QUOT_BITS-1:0]   o_quot
);
    import gmo_pkg::*;

    localparam logic [ANGLE_W-1:0] DIVISOR = ORIENT_STEP << BIT;

    logic                        take;
    logic                        r_valid;
    logic signed [GRAD_BITS-1:0] r_gx, r_gy;
    logic [GRAD_BITS-1:0]        r_mag;
    logic [OFFSET_W-1:0]         r_rem;
    logic [QUOT_BITS-1:0]        r_quot;

    assign take = ({1'b0, i_rem} >= DIVISOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gx   <= i_gx;
            r_gy   <= i_gy;
            r_mag  <= i_mag;
            r_rem  <= take ? i_rem - DIVISOR[OFFSET_W-1:0] : i_rem;
            r_quot <= {i_quot[QUOT_BITS-2:0], take};
        end
    end

    assign o_valid = r_valid;
    assign o_gx    = r_gx;
    assign o_gy    = r_gy;
    assign o_mag   = r_mag;
    assign o_rem   = r_rem;
    assign o_quot  = r_quot;

endmodule

// ===== rtl/gradient_magnitude_orientation_core.sv =====
// ============================================================================
// gradient_magnitude_orientation_core - 2x2 gradient, length and angle
// Streaming core: one pixel window in, one gradient result out.
// ============================================================================
// The core takes one 2x2 pixel window per clock and returns, for each window,
// the halved horizontal and vertical differences (truncated toward zero), the
// integer floor of their Euclidean length, and the orientation as an 8-bit
// bin index 0..254 over the full circle (bin 0 starts at -pi; an angle of
// exactly pi reads 0 and a zero gradient reads 127). Throughput is one
// window per clock while the skid register is empty. A result passes
// through the front stage, which loads at the edge that accepts its input
// transfer, then 46 rotation cells (the leading ones also settle the square
// root bit by bit), one offset stage, 9 quotient cells that divide the angle
// into bins, and the output register. The whole row of cells advances
// together; a skid register behind the output register lets the row run on
// for one more result after the sink stops, so an input transfer is still
// taken while a finished result waits. The core holds no state between
// windows and needs no setup after reset.
// ============================================================================
module gradient_magnitude_orientation_core #(
    parameter int unsigned PIXEL_BITS = gmo_pkg::PIXEL_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // pixel_00, pixel_01, pixel_10, pixel_11, zero pad to a byte boundary
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    input  logic [((4*PIXEL_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // gradient_x, gradient_y, magnitude, orientation, zero pad to a byte
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    output logic [((3*(PIXEL_BITS+1)+gmo_pkg::ORIENT_BITS+7)/8)*8-1:0] o_m_axis_tdata
);
    import gmo_pkg::*;

    localparam int unsigned GB    = PIXEL_BITS + 1;
    localparam int unsigned SQW   = 2 * GB - 1;
    localparam int unsigned XW    = GB + VEC_SHIFT + 2;
    localparam int unsigned RES_W = 3 * GB + ORIENT_BITS;
    localparam int unsigned OUT_W = ((RES_W + 7) / 8) * 8;

    // Row advance: stop only while the skid register holds a result
    logic en;

    // Rotation row links
    logic                 rv    [CORDIC_STEPS+1];
    logic signed [GB-1:0] rgx   [CORDIC_STEPS+1];
    logic signed [GB-1:0] rgy   [CORDIC_STEPS+1];
    logic [SQW-1:0]       rrem  [CORDIC_STEPS+1];
    logic [GB-1:0]        rroot [CORDIC_STEPS+1];
    logic signed [XW-1:0] rx    [CORDIC_STEPS+1];
    logic signed [XW-1:0] ry    [CORDIC_STEPS+1];
    t_angle               rz    [CORDIC_STEPS+1];

    // Offset stage
    t_angle               t_sum;
    logic                 r_t_valid;
    logic signed [GB-1:0] r_t_gx, r_t_gy;
    logic [GB-1:0]        r_t_mag;
    logic [OFFSET_W-1:0]  r_t;

    // Quotient row links
    logic                 dv    [QUOT_BITS+1];
    logic signed [GB-1:0] dgx   [QUOT_BITS+1];
    logic signed [GB-1:0] dgy   [QUOT_BITS+1];
    logic [GB-1:0]        dmag  [QUOT_BITS+1];
    logic [OFFSET_W-1:0]  drem  [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] dquot [QUOT_BITS+1];

    // Result assembly and output registers
    logic [ORIENT_BITS-1:0] orient;
    logic [RES_W-1:0]       res;
    logic                   r_out_valid, r_skid_valid;
    logic [RES_W-1:0]       r_out_data, r_skid_data;
    logic                   out_free;

    assign en              = ~r_skid_valid;
    assign o_s_axis_tready = en;

    // Difference, square and fold into the right half plane
    gmo_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_p00   (i_s_axis_tdata[PIXEL_BITS-1:0]),
        .i_p01   (i_s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
        .i_p10   (i_s_axis_tdata[3*PIXEL_BITS-1:2*PIXEL_BITS]),
        .i_p11   (i_s_axis_tdata[4*PIXEL_BITS-1:3*PIXEL_BITS]),
        .o_valid (rv[0]),
        .o_gx    (rgx[0]),
        .o_gy    (rgy[0]),
        .o_sq    (rrem[0]),
        .o_x     (rx[0]),
        .o_y     (ry[0]),
        .o_z     (rz[0])
    );
    // root starts empty; the remainder starts as the squared length
    assign rroot[0] = '0;

    // Row of rotation cells, one arctangent step each
    generate
        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
            gmo_rot_cell #(
                .GRAD_BITS (GB),
                .IDX       (i)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_valid (rv[i]),
                .i_gx    (rgx[i]),
                .i_gy    (rgy[i]),
                .i_rem   (rrem[i]),
                .i_root  (rroot[i]),
                .i_x     (rx[i]),
                .i_y     (ry[i]),
                .i_z     (rz[i]),
                .o_valid (rv[i+1]),
                .o_gx    (rgx[i+1]),
                .o_gy    (rgy[i+1]),
                .o_rem   (rrem[i+1]),
                .o_root  (rroot[i+1]),
                .o_x     (rx[i+1]),
                .o_y     (ry[i+1]),
                .o_z     (rz[i+1])
            );
        end
    endgenerate

    // Shift the angle from (-pi, pi] to [0, 2pi]; clamp rounding below zero
    assign t_sum = rz[CORDIC_STEPS] + PI_Q60;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (en) begin
            r_t_valid <= rv[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_gx  <= rgx[CORDIC_STEPS];
            r_t_gy  <= rgy[CORDIC_STEPS];
            r_t_mag <= rroot[CORDIC_STEPS];
            r_t     <= t_sum[ANGLE_W-1] ? '0 : t_sum[OFFSET_W-1:0];
        end
    end

    assign dv[0]    = r_t_valid;
    assign dgx[0]   = r_t_gx;
    assign dgy[0]   = r_t_gy;
    assign dmag[0]  = r_t_mag;
    assign drem[0]  = r_t;
    assign dquot[0] = '0;

    // Row of quotient cells, most significant bin bit first
    generate
        for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
            gmo_div_cell #(
                .GRAD_BITS (GB),
                .BIT       (QUOT_BITS - 1 - j)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en),
                .i_valid (dv[j]),
                .i_gx    (dgx[j]),
                .i_gy    (dgy[j]),
                .i_mag   (dmag[j]),
                .i_rem   (drem[j]),
                .i_quot  (dquot[j]),
                .o_valid (dv[j+1]),
                .o_gx    (dgx[j+1]),
                .o_gy    (dgy[j+1]),
                .o_mag   (dmag[j+1]),
                .o_rem   (drem[j+1]),
                .o_quot  (dquot[j+1])
            );
        end
    endgenerate

    // Orientation: horizontal gradients bypass the angle path; saturate the
    // top bin so the half turn never reaches 255
    always_comb begin
        if (dgy[QUOT_BITS] == '0) begin
            orient = dgx[QUOT_BITS][GB-1] ? ORIENT_PI : ORIENT_FLAT;
        end else if (dquot[QUOT_BITS] > QUOT_BITS'(ORIENT_MAX)) begin
            orient = ORIENT_MAX;
        end else begin
            orient = dquot[QUOT_BITS][ORIENT_BITS-1:0];
        end
        res = {orient, dmag[QUOT_BITS], dgy[QUOT_BITS], dgx[QUOT_BITS]};
    end

    // Output register with skid: the skid entry catches the one result that
    // the row delivers in the cycle the sink stalls
    assign out_free = ~r_out_valid | i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (dv[QUOT_BITS]) begin
            if (out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out_data <= r_skid_data;
            end
        end else if (dv[QUOT_BITS]) begin
            if (out_free) begin
                r_out_data <= res;
            end else begin
                r_skid_data <= res;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'(r_out_data);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench - gradient_magnitude_orientation_core
// Streams 2x2 pixel windows into the core under random source and sink
// stalls and then at full rate, predicts each result with a local integer
// rotation model, and compares every result transfer field by field, in order.
// ============================================================================

// One predicted result, in stream order
typedef struct packed {
    logic signed [8:0] grad_x;
    logic signed [8:0] grad_y;
    logic [8:0]        magnitude;
    logic [7:0]        orientation;
} gradient_result_t;

// Predict results from accepted windows and check them against the sink side.
// Angles are Q60 radians and the rotated vector is scaled by 2^40, so the
// bin index matches the core bit for bit.
class gradient_scoreboard;
    localparam int ROT_STEPS = 46;

    longint           rot_angle[ROT_STEPS];
    longint           pi_q60;
    longint           bin_width;
    gradient_result_t pending_gradients[$];
    int               errors;

    // atan(1/m) in Q60 by the alternating power series
    function longint unsigned atan_inv(longint unsigned m);
        longint unsigned pw;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned n;
        pw  = (64'd1 << 60) / m;
        sum = 0;
        n   = 0;
        while (pw != 0) begin
            term = pw / (2 * n + 1);
            sum  = n[0] ? sum - term : sum + term;
            pw   = pw / (m * m);
            n++;
        end
        return sum;
    endfunction

    function new();
        longint unsigned sum;
        longint unsigned term;
        longint unsigned n;
        longint unsigned s;
        pi_q60       = 16 * atan_inv(5) - 4 * atan_inv(239);
        rot_angle[0] = pi_q60 / 4;
        for (int i = 1; i < ROT_STEPS; i++) begin
            sum = 0;
            for (n = 0; i * (2 * n + 1) <= 60; n++) begin
                s    = i * (2 * n + 1);
                term = (64'd1 << (60 - s)) / (2 * n + 1);
                sum  = n[0] ? sum - term : sum + term;
            end
            rot_angle[i] = sum;
        end
        bin_width = (2 * pi_q60) / 255;
        errors    = 0;
    endfunction

    function int unsigned floor_sqrt(int unsigned v);
        int unsigned root;
        root = 0;
        for (int b = 9; b >= 0; b--) begin
            if ((root | (1 << b)) * (root | (1 << b)) <= v)
                root = root | (1 << b);
        end
        return root;
    endfunction

    // Vectoring rotation: drive y to zero, accumulate the angle, then bin it
    function logic [7:0] orientation_bin(int gx, int gy);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint t;
        longint k;
        if (gy == 0)
            return (gx < 0) ? gmo_pkg::ORIENT_PI : gmo_pkg::ORIENT_FLAT;
        x = longint'(gx) <<< 40;
        y = longint'(gy) <<< 40;
        z = 0;
        // fold the left half-plane onto the right one
        if (x < 0) begin
            z = (y > 0) ? pi_q60 : -pi_q60;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + rot_angle[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - rot_angle[i];
            end
        end
        t = z + pi_q60;
        if (t < 0)
            t = 0;
        k = t / bin_width;
        if (k > gmo_pkg::ORIENT_MAX)
            k = gmo_pkg::ORIENT_MAX;
        return k[7:0];
    endfunction

    // Note one accepted window: {pixel_11, pixel_10, pixel_01, pixel_00}
    function void note_window(logic [31:0] w);
        int               p00;
        int               p01;
        int               p10;
        int               p11;
        int               gx;
        int               gy;
        gradient_result_t r;
        p00           = w[7:0];
        p01           = w[15:8];
        p10           = w[23:16];
        p11           = w[31:24];
        gx            = (p11 + p01 - p10 - p00) / 2;
        gy            = (p11 + p10 - p01 - p00) / 2;
        r.grad_x      = gx[8:0];
        r.grad_y      = gy[8:0];
        r.magnitude   = 9'(floor_sqrt(gx * gx + gy * gy));
        r.orientation = orientation_bin(gx, gy);
        pending_gradients = {pending_gradients, r};
    endfunction

    function void flag(string field, int want, int got);
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                 $time, field, want, got);
    endfunction

    // Check one result transfer against the oldest prediction
    function void check_result(logic [39:0] d);
        gradient_result_t r;
        if (pending_gradients.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected result, expected none, actual %h", $time, d);
            return;
        end
        r = pending_gradients.pop_front();
        if (d[8:0] !== r.grad_x)
            flag("gradient_x", r.grad_x, $signed(d[8:0]));
        if (d[17:9] !== r.grad_y)
            flag("gradient_y", r.grad_y, $signed(d[17:9]));
        if (d[26:18] !== r.magnitude)
            flag("magnitude", r.magnitude, d[26:18]);
        if (d[34:27] !== r.orientation)
            flag("orientation", r.orientation, d[34:27]);
        if (d[39:35] !== 5'd0)
            flag("pad bits", 0, d[39:35]);
    endfunction

    function int pending_count();
        return pending_gradients.size();
    endfunction
endclass

module testbench;

    localparam int unsigned PIX   = 8;
    localparam int unsigned IN_W  = ((4 * PIX + 7) / 8) * 8;
    localparam int unsigned OUT_W = ((3 * (PIX + 1) + gmo_pkg::ORIENT_BITS + 7) / 8) * 8;
    localparam int unsigned ITEMS_PER_PHASE = 250;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_valid = 1'b0;
    logic [IN_W-1:0]  s_data  = '0;
    logic             m_ready = 1'b0;
    logic             o_s_axis_tready;
    logic             o_m_axis_tvalid;
    logic [OUT_W-1:0] o_m_axis_tdata;

    // Idle chances in percent, per side
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    gradient_scoreboard sb = new();

    gradient_magnitude_orientation_core #(
        .PIXEL_BITS(PIX)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(s_data),      // pixel_00, pixel_01, pixel_10, pixel_11
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(o_m_axis_tdata) // gradient_x, gradient_y, magnitude, orientation
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hard stop: far beyond the slowest correct run
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // Stall the sink at random; one assignment per edge
    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sample both handshakes with pre-edge values: a transfer is noted at the
    // edge where valid and ready were both high.
    always @(posedge i_clk) begin
        if (i_rst_n && s_valid && o_s_axis_tready)
            sb.note_window(s_data);
        if (i_rst_n && o_m_axis_tvalid && m_ready)
            sb.check_result(o_m_axis_tdata);
    end

    function automatic logic [31:0] window(int p00, int p01, int p10, int p11);
        return {p11[7:0], p10[7:0], p01[7:0], p00[7:0]};
    endfunction

    function automatic int clip8(int v);
        return (v < 0) ? 0 : (v > 255) ? 255 : v;
    endfunction

    // Mix of shapes: flat random, small gradients around a base level,
    // axis-aligned gradients and near-rail windows.
    function automatic logic [31:0] random_window();
        int kind;
        int base;
        int a;
        int c;
        kind = $urandom_range(99);
        base = $urandom_range(255);
        if (kind < 40) begin
            return $urandom;
        end else if (kind < 70) begin
            return window(clip8(base + $urandom_range(6) - 3), clip8(base + $urandom_range(6) - 3),
                          clip8(base + $urandom_range(6) - 3), clip8(base + $urandom_range(6) - 3));
        end else if (kind < 85) begin
            a = $urandom_range(255);
            c = $urandom_range(255);
            // equal pairs cancel one of the two differences
            if (kind[0])
                return window(c, a, c, a);
            else
                return window(c, c, a, a);
        end else begin
            return window($urandom_range(1) ? 255 - $urandom_range(3) : $urandom_range(3),
                          $urandom_range(1) ? 255 - $urandom_range(3) : $urandom_range(3),
                          $urandom_range(1) ? 255 - $urandom_range(3) : $urandom_range(3),
                          $urandom_range(1) ? 255 - $urandom_range(3) : $urandom_range(3));
        end
    endfunction

    // Offer one window and hold it until the transfer
    task automatic send_window(input logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] corner_windows[$];
        corner_windows = '{
            window(0, 0, 0, 0),         // zero gradient
            window(255, 255, 255, 255), // flat at the rail
            window(0, 255, 0, 255),     // largest positive x
            window(255, 0, 255, 0),     // largest negative x: angle exactly pi
            window(0, 0, 255, 255),     // largest positive y
            window(255, 255, 0, 0),     // largest negative y
            window(0, 0, 0, 255),
            window(255, 0, 0, 0),
            window(0, 255, 0, 0),
            window(0, 0, 255, 0),
            window(0, 1, 0, 0),         // odd sums truncate to zero
            window(1, 0, 0, 0),
            window(3, 0, 0, 0),
            window(2, 0, 2, 0),         // small negative x on the axis
            window(0, 2, 0, 2),
            window(255, 0, 255, 2),     // just below pi: saturates high
            window(255, 2, 255, 0),     // just above -pi: clamps low
            window(0, 255, 2, 255),
            window(2, 255, 0, 255),
            window(0, 0, 1, 1),
            window(1, 1, 0, 0),
            window(0, 255, 255, 255),
            window(204, 85, 51, 170)
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            // slow sink, then slow source, then full rate
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 74 : 0;
            recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 23 : 0;
            if (phase == 0) begin
                foreach (corner_windows[i])
                    send_window(corner_windows[i]);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_window(random_window());
        end
        s_valid <= 1'b0;

        // Drain, then watch for stray results past the pipeline depth
        while (sb.pending_count() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
